@@ rtl/bicycle_model_integrator_assert.svh @@
// Assertion macros for the bicycle model integrator
`ifndef BICYCLE_MODEL_INTEGRATOR_ASSERT_SVH
`define BICYCLE_MODEL_INTEGRATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BMI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmi assertion failed");
`define BMI_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmi assertion failed");
`else
`define BMI_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BMI_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/bmi_pkg.sv @@
// Shared types, constants and tables of the bicycle model integrator
package bmi_pkg;
   localparam int FRAC_BITS_DEF     = 16;
   localparam int CORDIC_STAGES_DEF = 20;
   localparam int DATA_W   = 32;
   localparam int OP_W     = 33;
   localparam int PROD_W   = 2 * OP_W;
   localparam int ANG_W    = 34;
   localparam int CSR_W    = 31;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_TIME_STEP     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INV_WHEELBASE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPEED_LIMIT   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEER_LIMIT   = 2'd3;

   localparam logic [16:0] TIME_STEP_RST     = 17'd13107;
   localparam logic [30:0] INV_WHEELBASE_RST = 31'd203403;
   localparam logic [30:0] SPEED_LIMIT_RST   = 31'd655360;
   localparam logic [16:0] STEER_LIMIT_RST   = 17'd45730;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   localparam logic signed [OP_W-1:0]  TURN_SCALE  = 33'sd683565276;
   localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [PROD_W:0]   wide_type;

   typedef struct packed {
      logic done;
      logic flip;
   } cordic_stat_type;

   typedef struct packed {
      logic done;
      logic sat;
   } div_stat_type;

   function automatic data_type sat32(input wide_type v);
      if (v > wide_type'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
      if (v < wide_type'(-33'sh80000000)) return 32'sh80000000;
      return v[DATA_W-1:0];
   endfunction

   // arctangent of 2^-i in binary angle units, 2^32 per turn
   function automatic logic signed [ANG_W-1:0] atan_turn(input logic [4:0] i);
      logic signed [ANG_W-1:0] r;
      case (i)
         5'd0:  r = 34'sd536870912;
         5'd1:  r = 34'sd316933406;
         5'd2:  r = 34'sd167458907;
         5'd3:  r = 34'sd85004756;
         5'd4:  r = 34'sd42667331;
         5'd5:  r = 34'sd21354465;
         5'd6:  r = 34'sd10679838;
         5'd7:  r = 34'sd5340245;
         5'd8:  r = 34'sd2670163;
         5'd9:  r = 34'sd1335087;
         5'd10: r = 34'sd667544;
         5'd11: r = 34'sd333772;
         5'd12: r = 34'sd166886;
         5'd13: r = 34'sd83443;
         5'd14: r = 34'sd41722;
         5'd15: r = 34'sd20861;
         5'd16: r = 34'sd10430;
         5'd17: r = 34'sd5215;
         5'd18: r = 34'sd2608;
         5'd19: r = 34'sd1304;
         5'd20: r = 34'sd652;
         5'd21: r = 34'sd326;
         5'd22: r = 34'sd163;
         5'd23: r = 34'sd81;
         5'd24: r = 34'sd41;
         5'd25: r = 34'sd20;
         5'd26: r = 34'sd10;
         5'd27: r = 34'sd5;
         5'd28: r = 34'sd3;
         5'd29: r = 34'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage

@@ rtl/bmi_if.sv @@
// Request and response channel interfaces
interface bmi_req_if import bmi_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     req_type;
   data_type accel;
   data_type steer_rate;
   data_type start_x;
   data_type start_y;
   data_type start_heading;
   data_type start_steer;
   data_type start_speed;
   modport source (output valid, req_type, accel, steer_rate, start_x, start_y,
                   start_heading, start_steer, start_speed, input ready);
   modport sink (input valid, req_type, accel, steer_rate, start_x, start_y,
                 start_heading, start_steer, start_speed, output ready);
endinterface

interface bmi_rsp_if import bmi_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type pos_x;
   data_type pos_y;
   data_type yaw;
   data_type steer_angle_out;
   data_type speed_out;
   modport source (output valid, pos_x, pos_y, yaw, steer_angle_out, speed_out,
                   input ready);
   modport sink (input valid, pos_x, pos_y, yaw, steer_angle_out, speed_out,
                 output ready);
endinterface

@@ rtl/bmi_cordic.sv @@
// Iterative rotation-mode CORDIC, one micro-rotation per cycle
module bmi_cordic import bmi_pkg::*; #(
   parameter int STAGES = CORDIC_STAGES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [DATA_W-1:0]       angle,
   output cordic_stat_type         stat,
   output logic signed [ANG_W-1:0] cos_out,
   output logic signed [ANG_W-1:0] sin_out
);
   localparam int N     = (STAGES > 30) ? 30 : STAGES;
   localparam int CNT_W = $clog2(N + 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic                    flip_ff, flip_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [ANG_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [ANG_W-1:0] xs, ys, at;

   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign at = atan_turn(5'(cnt_ff));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      flip_in = flip_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         // fold into [-1/4, 1/4) turn by adding a half turn
         flip_in = angle[DATA_W-1] ^ angle[DATA_W-2];
         z_in    = ANG_W'($signed({angle[DATA_W-1] ^ flip_in, angle[DATA_W-2:0]}));
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[ANG_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      flip_ff <= flip_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign stat.done = done_ff;
   assign stat.flip = flip_ff;
   assign cos_out   = x_ff;
   assign sin_out   = y_ff;
endmodule

@@ rtl/bmi_div.sv @@
// Restoring divider, one quotient bit per cycle, with overflow detect
module bmi_div import bmi_pkg::*; #(
   parameter int NUM_W = ANG_W + FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [ANG_W-1:0]  den,
   output div_stat_type      stat,
   output logic [DATA_W-1:0] quot
);
   localparam int HI_W  = NUM_W - (DATA_W - 1);
   localparam int CMP_W = (HI_W > ANG_W) ? HI_W : ANG_W;
   localparam int REM_W = ANG_W + 1;

   logic              busy_ff, busy_in, done_ff, done_in, sat_ff, sat_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [REM_W-1:0]  rem_ff, rem_in, trial;
   logic [DATA_W-1:0] low_ff, low_in, q_ff, q_in;
   logic              ge;

   assign trial = {rem_ff[REM_W-2:0], low_ff[DATA_W-1]};
   assign ge    = trial >= REM_W'(den);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      if (start) begin
         sat_in = CMP_W'(num[NUM_W-1:DATA_W-1]) >= CMP_W'(den);
         rem_in = REM_W'(num[NUM_W-1:DATA_W]);
         low_in = num[DATA_W-1:0];
         q_in   = '0;
         cnt_in = '0;
         if (sat_in) done_in = 1'b1;
         else busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? trial - REM_W'(den) : trial;
         q_in   = {q_ff[DATA_W-2:0], ge};
         low_in = {low_ff[DATA_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
   end

   assign stat.done = done_ff;
   assign stat.sat  = sat_ff;
   assign quot      = q_ff;
endmodule

@@ rtl/bicycle_model_integrator.sv @@
// Top level: sequencer, shared multiplier and state of the bicycle model
//
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | req_type, accel, steer_rate, start_*
//  rsp     | out | valid/ready  | pos_x, pos_y, yaw, steer_angle_out, speed_out
//  csr     | in  | csr_we       | csr_addr, csr_wdata
//
// The result of a load item shows in the next cycle.
// A step item uses two CORDIC runs and, for a positive cosine, a divide for
// tan, around one shared multiplier.
// One item is in flight at a time; req ready is low until the result is taken.
// Reset is synchronous and restores the register defaults and a zero state.
`include "bicycle_model_integrator_assert.svh"
module bicycle_model_integrator import bmi_pkg::*; #(
   parameter int FRAC_BITS     = FRAC_BITS_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   bmi_req_if.sink               req_chan,
   bmi_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]      csr_wdata
);
   localparam int ST_W  = 5;
   localparam int NUM_W = ANG_W + FRAC_BITS;
   localparam int CS_SH = 30 - FRAC_BITS;

   localparam logic [ST_W-1:0] ST_IDLE = 5'd0,  ST_SPD  = 5'd1,  ST_STR  = 5'd2,
                               ST_CLMP = 5'd3,  ST_TRN1 = 5'd4,  ST_COR1 = 5'd5,
                               ST_WC1  = 5'd6,  ST_DIV  = 5'd7,  ST_WD   = 5'd8,
                               ST_H1   = 5'd9,  ST_H2   = 5'd10, ST_H3   = 5'd11,
                               ST_H4   = 5'd12, ST_TRN2 = 5'd13, ST_COR2 = 5'd14,
                               ST_WC2  = 5'd15, ST_X1   = 5'd16, ST_X2   = 5'd17,
                               ST_X3   = 5'd18, ST_Y2   = 5'd19, ST_Y3   = 5'd20,
                               ST_OUT  = 5'd21;

   logic [ST_W-1:0]  state_ff, state_in;
   logic [16:0]      time_step_ff, steer_limit_ff;
   logic [30:0]      inv_wheelbase_ff, speed_limit_ff;
   data_type         x_ff, x_in, y_ff, y_in, head_ff, head_in;
   data_type         steer_ff, steer_in, speed_ff, speed_in;
   data_type         accel_ff, rate_ff, tan_ff, tan_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [OP_W-1:0]   op_a, op_b;
   wide_type         sh, sum;
   data_type         mq;
   logic             accept;

   logic                    cor_start;
   logic [DATA_W-1:0]       cor_angle;
   cordic_stat_type         cor_stat;
   logic signed [ANG_W-1:0] cor_cos, cor_sin, c_sh, s_sh, s_mag;
   logic signed [OP_W-1:0]  c_val, s_val;
   logic                    div_start;
   div_stat_type            div_stat;
   logic [DATA_W-1:0]       div_q;

   bmi_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
      .clock(clock), .reset(reset), .start(cor_start), .angle(cor_angle),
      .stat(cor_stat), .cos_out(cor_cos), .sin_out(cor_sin)
   );

   assign s_mag = cor_sin[ANG_W-1] ? -cor_sin : cor_sin;

   bmi_div #(.NUM_W(NUM_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num({s_mag, {FRAC_BITS{1'b0}}}), .den(cor_cos),
      .stat(div_stat), .quot(div_q)
   );

   assign accept    = req_chan.valid && req_chan.ready;
   assign cor_angle = prod_ff[FRAC_BITS+DATA_W-1:FRAC_BITS];
   assign cor_start = (state_ff == ST_COR1) || (state_ff == ST_COR2);
   assign div_start = (state_ff == ST_DIV) && (cor_cos > 0);

   // cos and sin in Q.FRAC_BITS, unfolded
   assign c_sh  = cor_cos >>> CS_SH;
   assign s_sh  = cor_sin >>> CS_SH;
   assign c_val = OP_W'(cor_stat.flip ? -c_sh : c_sh);
   assign s_val = OP_W'(cor_stat.flip ? -s_sh : s_sh);

   assign sh = wide_type'(prod_ff >>> FRAC_BITS);
   assign mq = sat32(sh);

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_SPD:  begin op_a = OP_W'(accel_ff); op_b = OP_W'(time_step_ff); end
         ST_STR:  begin op_a = OP_W'(rate_ff);  op_b = OP_W'(time_step_ff); end
         ST_TRN1: begin op_a = OP_W'(steer_ff); op_b = TURN_SCALE; end
         ST_H1:   begin op_a = OP_W'(speed_ff); op_b = OP_W'(tan_ff); end
         ST_H2:   begin op_a = OP_W'(mq);       op_b = OP_W'(time_step_ff); end
         ST_H3:   begin op_a = OP_W'(mq);       op_b = OP_W'(inv_wheelbase_ff); end
         ST_TRN2: begin op_a = OP_W'(head_ff);  op_b = TURN_SCALE; end
         ST_X1:   begin op_a = OP_W'(speed_ff); op_b = c_val; end
         ST_X2:   begin op_a = OP_W'(mq);       op_b = OP_W'(time_step_ff); end
         ST_X3:   begin op_a = OP_W'(speed_ff); op_b = s_val; end
         ST_Y2:   begin op_a = OP_W'(mq);       op_b = OP_W'(time_step_ff); end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      head_in  = head_ff;
      steer_in = steer_ff;
      speed_in = speed_ff;
      tan_in   = tan_ff;
      sum      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.req_type == REQ_LOAD) begin
                  x_in     = req_chan.start_x;
                  y_in     = req_chan.start_y;
                  head_in  = req_chan.start_heading;
                  steer_in = req_chan.start_steer;
                  speed_in = req_chan.start_speed;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_SPD;
               end
            end
         end
         ST_SPD:  state_in = ST_STR;
         ST_STR: begin
            sum = wide_type'(speed_ff) + sh;
            if (sum > wide_type'(speed_limit_ff)) speed_in = DATA_W'(speed_limit_ff);
            else if (sum < 0) speed_in = '0;
            else speed_in = sum[DATA_W-1:0];
            state_in = ST_CLMP;
         end
         ST_CLMP: begin
            sum = wide_type'(steer_ff) + sh;
            if (sum > wide_type'(steer_limit_ff)) steer_in = DATA_W'(steer_limit_ff);
            else if (sum < -wide_type'(steer_limit_ff))
               steer_in = -DATA_W'(steer_limit_ff);
            else steer_in = sum[DATA_W-1:0];
            state_in = ST_TRN1;
         end
         ST_TRN1: state_in = ST_COR1;
         ST_COR1: state_in = ST_WC1;
         ST_WC1:  if (cor_stat.done) state_in = ST_DIV;
         ST_DIV: begin
            // non-positive cosine: tan takes the limit with the sign of sin
            if (cor_cos > 0) state_in = ST_WD;
            else begin
               tan_in   = cor_sin[ANG_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
               state_in = ST_H1;
            end
         end
         ST_WD: begin
            if (div_stat.done) begin
               if (div_stat.sat)
                  tan_in = cor_sin[ANG_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
               else
                  tan_in = cor_sin[ANG_W-1] ? -div_q : div_q;
               state_in = ST_H1;
            end
         end
         ST_H1:   state_in = ST_H2;
         ST_H2:   state_in = ST_H3;
         ST_H3:   state_in = ST_H4;
         ST_H4: begin
            head_in  = sat32(wide_type'(head_ff) + wide_type'(mq));
            state_in = ST_TRN2;
         end
         ST_TRN2: state_in = ST_COR2;
         ST_COR2: state_in = ST_WC2;
         ST_WC2:  if (cor_stat.done) state_in = ST_X1;
         ST_X1:   state_in = ST_X2;
         ST_X2:   state_in = ST_X3;
         ST_X3: begin
            x_in     = sat32(wide_type'(x_ff) + wide_type'(mq));
            state_in = ST_Y2;
         end
         ST_Y2:   state_in = ST_Y3;
         ST_Y3: begin
            y_in     = sat32(wide_type'(y_ff) + wide_type'(mq));
            state_in = ST_OUT;
         end
         ST_OUT:  if (rsp_chan.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         time_step_ff     <= TIME_STEP_RST;
         inv_wheelbase_ff <= INV_WHEELBASE_RST;
         speed_limit_ff   <= SPEED_LIMIT_RST;
         steer_limit_ff   <= STEER_LIMIT_RST;
         x_ff     <= '0;
         y_ff     <= '0;
         head_ff  <= '0;
         steer_ff <= '0;
         speed_ff <= '0;
      end else begin
         state_ff <= state_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         head_ff  <= head_in;
         steer_ff <= steer_in;
         speed_ff <= speed_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_TIME_STEP:     time_step_ff     <= csr_wdata[16:0];
               CSR_INV_WHEELBASE: inv_wheelbase_ff <= csr_wdata;
               CSR_SPEED_LIMIT:   speed_limit_ff   <= csr_wdata;
               CSR_STEER_LIMIT:   steer_limit_ff   <= csr_wdata[16:0];
               default: ;
            endcase
         end
      end
      prod_ff <= op_a * op_b;
      tan_ff  <= tan_in;
      if (accept) begin
         accel_ff <= req_chan.accel;
         rate_ff  <= req_chan.steer_rate;
      end
   end

   assign req_chan.ready           = (state_ff == ST_IDLE);
   assign rsp_chan.valid           = (state_ff == ST_OUT);
   assign rsp_chan.pos_x           = x_ff;
   assign rsp_chan.pos_y           = y_ff;
   assign rsp_chan.yaw             = head_ff;
   assign rsp_chan.steer_angle_out = steer_ff;
   assign rsp_chan.speed_out       = speed_ff;

   `BMI_ASSERT_IMP(a_ready_no_rsp, clock, reset, req_chan.ready, !rsp_chan.valid)
   `BMI_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, !req_chan.ready)
   `BMI_ASSERT_IMP(a_div_pos_den, clock, reset, div_start, cor_cos > 0)
endmodule

@@ bench/bicycle_model_integrator_tb.sv @@
// Self-checking testbench for the bicycle model integrator
`timescale 1ns / 1ps
module bicycle_model_integrator_tb import bmi_pkg::*; ();

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RSP_HOLD_CYCLES = 400;

   typedef struct packed {
      logic     kind;
      data_type accel;
      data_type steer_rate;
      data_type sx;
      data_type sy;
      data_type sh;
      data_type sst;
      data_type ssp;
   } drive_item_type;

   typedef struct packed {
      data_type x;
      data_type y;
      data_type heading;
      data_type steer;
      data_type speed;
   } vehicle_state_type;

   typedef struct packed {
      logic              typed;
      drive_item_type    item;
      vehicle_state_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   bmi_req_if req ();
   bmi_rsp_if rsp ();

   bicycle_model_integrator uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state and configuration
   longint dt_q, inv_wb_q, speed_max_q, steer_max_q;
   longint px, py, ph, pst, pv;

   vehicle_state_type expected_states[$];
   int fail_count = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int rsp_hold_left = 0;
   int stall_count = 0;

   function automatic longint sat_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint fix_mul(longint a, longint b);
      return sat_word((a * b) >>> 16);
   endfunction

   // rotation CORDIC on the folded angle, Q2.30 results
   function automatic logic rotate_angle(longint ang, output longint c, output longint s);
      logic [31:0] t;
      logic flip;
      longint z, xr, yr, nx;
      t = 32'((ang * 64'sd683565276) >>> 16);
      flip = ((t + 32'h4000_0000) & 32'h8000_0000) != 0;
      if (flip) t = t ^ 32'h8000_0000;
      z = longint'(signed'(t));
      xr = 64'sd652032874;
      yr = 0;
      for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
         if (z >= 0) begin
            nx = xr - (yr >>> i);
            yr = yr + (xr >>> i);
            z -= longint'(atan_turn(5'(i)));
         end else begin
            nx = xr + (yr >>> i);
            yr = yr - (xr >>> i);
            z += longint'(atan_turn(5'(i)));
         end
         xr = nx;
      end
      c = xr;
      s = yr;
      return flip;
   endfunction

   function automatic longint tangent(longint ang);
      longint c, s;
      void'(rotate_angle(ang, c, s));
      // non-positive cosine: saturate with the sign of the sine
      if (c <= 0) return (s >= 0) ? 64'sd2147483647 : -64'sd2147483648;
      return sat_word((s * 65536) / c);
   endfunction

   function automatic vehicle_state_type advance_vehicle(drive_item_type it);
      longint v, st, c, s;
      logic flip;
      vehicle_state_type r;
      if (it.kind == REQ_LOAD) begin
         px = it.sx; py = it.sy; ph = it.sh; pst = it.sst; pv = it.ssp;
      end else begin
         v = pv + ((longint'(it.accel) * dt_q) >>> 16);
         if (v > speed_max_q) v = speed_max_q;
         if (v < 0) v = 0;
         pv = v;
         st = pst + ((longint'(it.steer_rate) * dt_q) >>> 16);
         if (st > steer_max_q) st = steer_max_q;
         if (st < -steer_max_q) st = -steer_max_q;
         pst = st;
         ph = sat_word(ph + fix_mul(fix_mul(fix_mul(v, tangent(st)), dt_q), inv_wb_q));
         flip = rotate_angle(ph, c, s);
         c = c >>> 14;
         s = s >>> 14;
         if (flip) begin
            c = -c;
            s = -s;
         end
         px = sat_word(px + fix_mul(fix_mul(v, c), dt_q));
         py = sat_word(py + fix_mul(fix_mul(v, s), dt_q));
      end
      r.x = data_type'(px); r.y = data_type'(py); r.heading = data_type'(ph);
      r.steer = data_type'(pst); r.speed = data_type'(pv);
      return r;
   endfunction

   task automatic write_csr(logic [CSR_ADDR_W-1:0] addr, logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (addr)
         CSR_TIME_STEP:     dt_q = longint'(data[16:0]);
         CSR_INV_WHEELBASE: inv_wb_q = longint'(data);
         CSR_SPEED_LIMIT:   speed_max_q = longint'(data);
         CSR_STEER_LIMIT:   steer_max_q = longint'(data[16:0]);
         default: ;
      endcase
   endtask

   task automatic configure(int ts, int iw, int sl, int stl);
      write_csr(CSR_TIME_STEP, CSR_W'(ts));
      write_csr(CSR_INV_WHEELBASE, CSR_W'(iw));
      write_csr(CSR_SPEED_LIMIT, CSR_W'(sl));
      write_csr(CSR_STEER_LIMIT, CSR_W'(stl));
   endtask

   // present one item and hold it until the block takes it
   task automatic send_item(drive_item_type it, logic typed, vehicle_state_type want);
      vehicle_state_type pred;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.req_type <= it.kind;
      req.accel <= it.accel;
      req.steer_rate <= it.steer_rate;
      req.start_x <= it.sx;
      req.start_y <= it.sy;
      req.start_heading <= it.sh;
      req.start_steer <= it.sst;
      req.start_speed <= it.ssp;
      do @(posedge clock); while (!req.ready);
      pred = advance_vehicle(it);
      expected_states.push_back(typed ? want : pred);
   endtask

   task automatic drain();
      @(negedge clock);
      req.valid <= 1'b0;
      wait (expected_states.size() == 0);
      repeat (8) @(negedge clock);
   endtask

   function automatic data_type small_signed(int m);
      return data_type'(int'($urandom_range(0, 2 * m)) - m);
   endfunction

   function automatic drive_item_type random_item();
      drive_item_type it;
      it.accel = $urandom;
      it.steer_rate = $urandom;
      it.sx = $urandom;
      it.sy = $urandom;
      it.sh = $urandom;
      it.sst = $urandom;
      it.ssp = $urandom;
      if ($urandom_range(99) < 10) begin
         it.kind = REQ_LOAD;
         if ($urandom_range(3) != 0) begin
            it.sx = small_signed(100 << 16);
            it.sy = small_signed(100 << 16);
            it.sh = small_signed(7 << 16);
            it.sst = small_signed(1 << 16);
            it.ssp = data_type'($urandom_range(0, 12 << 16));
         end
      end else begin
         it.kind = REQ_STEP;
         if ($urandom_range(4) != 0) begin
            it.accel = small_signed(8 << 16);
            it.steer_rate = small_signed(2 << 16);
         end
      end
      return it;
   endfunction

   task automatic run_random(int count);
      vehicle_state_type none;
      none = '0;
      for (int n = 0; n < count; n++) begin
         // pause once until the block has returned everything
         if (n == count / 2 && count > 100) drain();
         send_item(random_item(), 1'b0, none);
      end
      drain();
   endtask

   directed_row_type directed_rows[] = '{
      '{1'b1, '{REQ_STEP, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
         '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}},
      '{1'b1, '{REQ_LOAD, 32'sd0, 32'sd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
         32'h7FFFFFFF, 32'h7FFFFFFF},
         '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}},
      '{1'b0, '{REQ_STEP, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
         '0},
      '{1'b1, '{REQ_LOAD, 32'sd0, 32'sd0, 32'h80000000, 32'h80000000, 32'h80000000,
         32'h80000000, 32'h80000000},
         '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000}},
      // negative speed and steering clamp, nothing else moves
      '{1'b1, '{REQ_STEP, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
         '{32'h80000000, 32'h80000000, 32'h80000000, -32'sd45730, 32'sd0}},
      '{1'b0, '{REQ_LOAD, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd327680}, '0},
      '{1'b0, '{REQ_STEP, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
         '0},
      '{1'b0, '{REQ_STEP, 32'h80000000, 32'h80000000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
         '0},
      '{1'b0, '{REQ_LOAD, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd102944, 32'sd45730,
         32'sd655360}, '0},
      '{1'b0, '{REQ_STEP, 32'sd65536, -32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
         '0},
      '{1'b0, '{REQ_LOAD, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd205887, 32'sd0,
         32'sd2000000}, '0},
      '{1'b0, '{REQ_STEP, 32'sd0, 32'sd300000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, '0},
      '{1'b0, '{REQ_LOAD, 32'sd0, 32'sd0, 32'h7FFF0000, 32'h80010000, 32'h7FFFFF00, 32'sd0,
         32'sd655360}, '0},
      '{1'b0, '{REQ_STEP, 32'sd0, 32'sd500000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, '0},
      '{1'b0, '{REQ_STEP, 32'sd0, 32'sd500000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, '0}
   };

   // pressure steps: steering at the limit of a right angle, full speed
   directed_row_type limit_rows[] = '{
      '{1'b0, '{REQ_LOAD, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'h7FFF0000, 32'sd102944,
         32'h7FFFFFFF}, '0},
      '{1'b0, '{REQ_STEP, 32'sd0, 32'h7FFFFFFF, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, '0},
      '{1'b0, '{REQ_STEP, 32'sd0, 32'h80000000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, '0}
   };

   // response ready: long hold on request, otherwise random stalls
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp.ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      vehicle_state_type exp_s;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_states.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected result x=%0d", rsp.pos_x);
         end else begin
            exp_s = expected_states.pop_front();
            if (rsp.pos_x !== exp_s.x || rsp.pos_y !== exp_s.y ||
                rsp.yaw !== exp_s.heading || rsp.steer_angle_out !== exp_s.steer ||
                rsp.speed_out !== exp_s.speed) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch exp x=%0d y=%0d h=%0d st=%0d v=%0d got %0d %0d %0d %0d %0d",
                     exp_s.x, exp_s.y, exp_s.heading, exp_s.steer, exp_s.speed,
                     rsp.pos_x, rsp.pos_y, rsp.yaw, rsp.steer_angle_out, rsp.speed_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         stall_count <= 0;
      end else if (stall_count >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   initial begin
      vehicle_state_type none;
      none = '0;
      req.valid = 1'b0;
      req.req_type = REQ_LOAD;
      req.accel = '0;
      req.steer_rate = '0;
      req.start_x = '0;
      req.start_y = '0;
      req.start_heading = '0;
      req.start_steer = '0;
      req.start_speed = '0;
      dt_q = longint'(TIME_STEP_RST);
      inv_wb_q = longint'(INV_WHEELBASE_RST);
      speed_max_q = longint'(SPEED_LIMIT_RST);
      steer_max_q = longint'(STEER_LIMIT_RST);
      px = 0; py = 0; ph = 0; pst = 0; pv = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct = 12;
      receiver_idle_pct = 87;
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      run_random(180);

      configure(65536, 32'h7FFFFFFF, 32'h7FFFFFFF, 102944);
      foreach (limit_rows[i]) send_item(limit_rows[i].item, 1'b0, none);
      run_random(180);

      sender_idle_pct = 87;
      receiver_idle_pct = 12;
      configure(0, 0, 0, 0);
      run_random(120);

      configure(6554, 100000, 1310720, 20000);
      run_random(200);

      // block the response side while items keep coming
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      configure(int'(TIME_STEP_RST), int'(INV_WHEELBASE_RST), int'(SPEED_LIMIT_RST),
         int'(STEER_LIMIT_RST));
      rsp_hold_left = RSP_HOLD_CYCLES;
      run_random(300);

      repeat (100) @(posedge clock);
      if (expected_states.size() != 0) fail_count++;
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
